@@ hdl/trag_pkg.sv @@
`default_nettype none

package trag_pkg;

  // tensor geometry
  localparam int NUM_DIMS = 4;
  localparam int DIM_W    = 2;
  localparam int RANK_W   = 3;
  localparam int TURNS_W  = 2;
  localparam int SIZE_W   = 16;
  localparam int OFF_W    = 32;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef logic [SIZE_W-1:0]        extent_t;
  typedef logic [OFF_W-1:0]         off_t;
  typedef logic signed [SIZE_W:0]   didx_t;
  typedef logic [DIM_W-1:0]         dim_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANK    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_A = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_B = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURNS   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE0   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE1   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE2   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE3   = 4'd7;

  // rank limits and reset values
  localparam logic [RANK_W-1:0]  RANK_MIN      = 3'd2;
  localparam logic [RANK_W-1:0]  RANK_MAX      = 3'd4;
  localparam logic [RANK_W-1:0]  RANK_RST      = 3'd2;
  localparam dim_t               PLANE_A_RST   = 2'd0;
  localparam dim_t               PLANE_B_RST   = 2'd1;
  localparam logic [TURNS_W-1:0] TURNS_RST     = 2'd1;

  // rotation amounts
  localparam logic [TURNS_W-1:0] TURN_90  = 2'd1;
  localparam logic [TURNS_W-1:0] TURN_180 = 2'd2;
  localparam logic [TURNS_W-1:0] TURN_270 = 2'd3;

  // cycles the strides need after a register write
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

endpackage

`default_nettype wire

@@ hdl/tensor_rot90_address_generator.sv @@
`default_nettype none

// channel   handshake                    payload
// --------  ---------------------------  ------------------------------------
// in        in_valid / in_ready          restart
// out       out_valid / out_ready        source_offset, dest_offset, last
// cfg       cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One word per cycle when not stalled; stages: index register, a row of
// parallel stride multipliers, then the offset adders into the output register.
// Each stage holds its word until the next one frees, so words keep coming
// into empty stages while the output waits on out_ready.
// After reset and after each register write in_ready stays low while the stride
// products settle; cfg_ready is always high.

module tensor_rot90_address_generator (
  input  wire                               clk,
  input  wire                               rst,
  // input words
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               restart,
  // result words
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [trag_pkg::OFF_W-1:0]        source_offset,
  output logic [trag_pkg::OFF_W-1:0]        dest_offset,
  output logic                              last,
  // register writes
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [trag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [trag_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int ND   = trag_pkg::NUM_DIMS;
  localparam int EXTW = trag_pkg::OFF_W - trag_pkg::SIZE_W - 1;

  // configuration registers
  logic [trag_pkg::RANK_W-1:0]  rank;
  trag_pkg::dim_t               plane_dim_a;
  trag_pkg::dim_t               plane_dim_b;
  logic [trag_pkg::TURNS_W-1:0] quarter_turns;
  trag_pkg::extent_t            size_dim [ND];

  // derived geometry
  logic [trag_pkg::RANK_W-1:0]  rank_eff;
  trag_pkg::extent_t            eff [ND];
  trag_pkg::extent_t            dsz [ND];
  logic                         odd_turn;

  // stride pipeline
  trag_pkg::extent_t            sa_e3, sa_e1, da_e3, da_e1;
  trag_pkg::off_t               sa_p, da_p;
  trag_pkg::off_t               src_stride [ND];
  trag_pkg::off_t               dst_stride [ND];
  logic [1:0]                   settle;

  // walk state
  trag_pkg::extent_t            counters [ND];
  trag_pkg::extent_t            cnt_next [ND];
  trag_pkg::extent_t            idx [ND];
  trag_pkg::didx_t              dst [ND];
  logic [ND-1:0]                wrap;
  trag_pkg::dim_t               order [ND];
  logic [2:0]                   n_ord;
  logic                         carry;
  trag_pkg::didx_t              flip_a, flip_b;

  // pipeline stages
  logic                         in_acc, cfg_acc;
  logic                         out_en, s2_en, s1_en;
  logic                         s1_valid, s2_valid;
  trag_pkg::extent_t            s1_idx [ND];
  trag_pkg::didx_t              s1_dst [ND];
  logic                         s1_last, s2_last;
  trag_pkg::off_t               s2_sp [ND];
  trag_pkg::off_t               s2_dp [ND];

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rank          <= trag_pkg::RANK_RST;
      plane_dim_a   <= trag_pkg::PLANE_A_RST;
      plane_dim_b   <= trag_pkg::PLANE_B_RST;
      quarter_turns <= trag_pkg::TURNS_RST;
      for (int d = 0; d < ND; d++) begin
        size_dim[d] <= trag_pkg::extent_t'(1);
      end
    end else if (cfg_acc) begin
      unique case (cfg_index)
        trag_pkg::REG_RANK:    rank          <= cfg_data[trag_pkg::RANK_W-1:0];
        trag_pkg::REG_PLANE_A: plane_dim_a   <= cfg_data[trag_pkg::DIM_W-1:0];
        trag_pkg::REG_PLANE_B: plane_dim_b   <= cfg_data[trag_pkg::DIM_W-1:0];
        trag_pkg::REG_TURNS:   quarter_turns <= cfg_data[trag_pkg::TURNS_W-1:0];
        trag_pkg::REG_SIZE0:   size_dim[0]   <= cfg_data[trag_pkg::SIZE_W-1:0];
        trag_pkg::REG_SIZE1:   size_dim[1]   <= cfg_data[trag_pkg::SIZE_W-1:0];
        trag_pkg::REG_SIZE2:   size_dim[2]   <= cfg_data[trag_pkg::SIZE_W-1:0];
        trag_pkg::REG_SIZE3:   size_dim[3]   <= cfg_data[trag_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes, clamped rank, swapped output sizes
  always_comb begin
    if (rank < trag_pkg::RANK_MIN)      rank_eff = trag_pkg::RANK_MIN;
    else if (rank > trag_pkg::RANK_MAX) rank_eff = trag_pkg::RANK_MAX;
    else                                rank_eff = rank;
    odd_turn = quarter_turns[0] && (plane_dim_a != plane_dim_b);
    for (int d = 0; d < ND; d++) begin
      if ((trag_pkg::RANK_W'(d) < rank_eff) && (size_dim[d] != '0)) eff[d] = size_dim[d];
      else eff[d] = trag_pkg::extent_t'(1);
    end
    for (int d = 0; d < ND; d++) begin
      dsz[d] = eff[d];
      if (odd_turn && (trag_pkg::DIM_W'(d) == plane_dim_a)) dsz[d] = eff[plane_dim_b];
      else if (odd_turn && (trag_pkg::DIM_W'(d) == plane_dim_b)) dsz[d] = eff[plane_dim_a];
    end
  end

  // strides: partial product registered first, then the full product registered from it
  always_ff @(posedge clk) begin
    sa_e3 <= eff[3];
    sa_e1 <= eff[1];
    sa_p  <= trag_pkg::off_t'(eff[3]) * trag_pkg::off_t'(eff[2]);
    da_e3 <= dsz[3];
    da_e1 <= dsz[1];
    da_p  <= trag_pkg::off_t'(dsz[3]) * trag_pkg::off_t'(dsz[2]);
    src_stride[3] <= trag_pkg::off_t'(1);
    src_stride[2] <= trag_pkg::off_t'(sa_e3);
    src_stride[1] <= sa_p;
    src_stride[0] <= sa_p * trag_pkg::off_t'(sa_e1);
    dst_stride[3] <= trag_pkg::off_t'(1);
    dst_stride[2] <= trag_pkg::off_t'(da_e3);
    dst_stride[1] <= da_p;
    dst_stride[0] <= da_p * trag_pkg::off_t'(da_e1);
  end

  // hold off input words until the strides follow the registers
  always_ff @(posedge clk) begin
    if (rst || cfg_acc) begin
      settle <= trag_pkg::SETTLE_CYCLES;
    end else if (settle != '0) begin
      settle <= settle - 2'd1;
    end
  end

  // current position, wrap flags and rotated indices
  always_comb begin
    for (int d = 0; d < ND; d++) begin
      idx[d]  = restart ? '0 : counters[d];
      wrap[d] = ({1'b0, idx[d]} + 17'd1) >= {1'b0, eff[d]};
    end
    flip_a = $signed({1'b0, eff[plane_dim_a]}) - $signed({1'b0, idx[plane_dim_a]})
             - 17'sd1;
    flip_b = $signed({1'b0, eff[plane_dim_b]}) - $signed({1'b0, idx[plane_dim_b]})
             - 17'sd1;
    for (int d = 0; d < ND; d++) begin
      dst[d] = $signed({1'b0, idx[d]});
    end
    if (plane_dim_a != plane_dim_b) begin
      case (quarter_turns)
        trag_pkg::TURN_90: begin
          dst[plane_dim_a] = $signed({1'b0, idx[plane_dim_b]});
          dst[plane_dim_b] = flip_a;
        end
        trag_pkg::TURN_180: begin
          dst[plane_dim_a] = flip_a;
          dst[plane_dim_b] = flip_b;
        end
        trag_pkg::TURN_270: begin
          dst[plane_dim_b] = $signed({1'b0, idx[plane_dim_a]});
          dst[plane_dim_a] = flip_b;
        end
        default: ;
      endcase
    end
  end

  // walk order: plane b, plane a, then the rest ascending
  always_comb begin
    for (int p = 0; p < ND; p++) begin
      order[p] = '0;
    end
    n_ord = '0;
    if (plane_dim_a != plane_dim_b) begin
      order[0] = plane_dim_b;
      n_ord    = 3'd1;
    end
    order[n_ord[trag_pkg::DIM_W-1:0]] = plane_dim_a;
    n_ord = n_ord + 3'd1;
    for (int d = 0; d < ND; d++) begin
      if ((trag_pkg::DIM_W'(d) != plane_dim_a) && (trag_pkg::DIM_W'(d) != plane_dim_b)) begin
        order[n_ord[trag_pkg::DIM_W-1:0]] = trag_pkg::DIM_W'(d);
        n_ord = n_ord + 3'd1;
      end
    end
  end

  // ripple the carry through the walk order
  always_comb begin
    carry = 1'b1;
    for (int d = 0; d < ND; d++) begin
      cnt_next[d] = idx[d];
    end
    for (int p = 0; p < ND; p++) begin
      if (carry) begin
        if (wrap[order[p]]) begin
          cnt_next[order[p]] = '0;
        end else begin
          cnt_next[order[p]] = idx[order[p]] + trag_pkg::extent_t'(1);
          carry = 1'b0;
        end
      end
    end
  end

  // stage enables
  assign out_en   = !out_valid || out_ready;
  assign s2_en    = !s2_valid || out_en;
  assign s1_en    = !s1_valid || s2_en;
  assign in_ready = s1_en && (settle == '0);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int d = 0; d < ND; d++) begin
        counters[d] <= '0;
      end
    end else begin
      if (s1_en)  s1_valid  <= in_acc;
      if (s2_en)  s2_valid  <= s1_valid;
      if (out_en) out_valid <= s2_valid;
      if (in_acc) begin
        for (int d = 0; d < ND; d++) begin
          counters[d] <= cnt_next[d];
        end
      end
    end
  end

  // index register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx  <= idx;
      s1_dst  <= dst;
      s1_last <= &wrap;
    end
  end

  // per-dimension stride products
  always_ff @(posedge clk) begin
    if (s2_en) begin
      for (int d = 0; d < ND; d++) begin
        s2_sp[d] <= trag_pkg::off_t'(s1_idx[d]) * src_stride[d];
        s2_dp[d] <= {{EXTW{s1_dst[d][trag_pkg::SIZE_W]}}, s1_dst[d]} * dst_stride[d];
      end
      s2_last <= s1_last;
    end
  end

  // offset sums into the output register
  always_ff @(posedge clk) begin
    if (out_en) begin
      source_offset <= (s2_sp[0] + s2_sp[1]) + (s2_sp[2] + s2_sp[3]);
      dest_offset   <= (s2_dp[0] + s2_dp[1]) + (s2_dp[2] + s2_dp[3]);
      last          <= s2_last;
    end
  end

endmodule

`default_nettype wire
